// ===== hw/rtl/psq_pkg.sv =====
// shared types and constants of the pending signal queue
package psq_pkg;

  // queue geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // item field widths
  localparam int CMD_W       = 2;
  localparam int ID_W        = 4;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

endpackage

// ===== hw/rtl/psq_ram.sv =====
// generic simple dual port ram with registered read
module psq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pending_signal_queue.sv =====
// pending signal queue: ordered id queue with append, pop, remove and find
//
//   channel | valid    | ready     | payload
//   --------+----------+-----------+---------------------------------------------
//   input   | in_valid | in_ready  | command, sig_id
//   output  | out_valid| out_ready | status, out_id, head_valid, head_id, entry_count
//
// one item at a time; the result is offered in the cycle after the last work cycle
// append, and any command on an empty queue, is done in the idle state alone
// find: the idle state, then one scan step per entry compared (one slot read per cycle)
// remove: the idle state, the scan steps, then one shift step per entry moved up; pop: idle, then the shift steps
// the single read port of the slot ram is why slots are scanned and moved one at a time
// reset empties the queue at once; a stalled result holds until out_ready
module pending_signal_queue (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [psq_pkg::CMD_W-1:0]            command,
  input  logic [psq_pkg::ID_W-1:0]             sig_id,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [psq_pkg::STATUS_W-1:0]         status,
  output logic [psq_pkg::ID_W-1:0]             out_id,
  output logic                                 head_valid,
  output logic [psq_pkg::ID_W-1:0]             head_id,
  output logic [psq_pkg::COUNT_OUT_W-1:0]      entry_count
);

  psq_pkg::state_t                state, state_next;
  psq_pkg::cmd_t                  cmd_q, cmd_next;
  logic [psq_pkg::ID_W-1:0]       id_q, id_next;
  logic [psq_pkg::IDX_W-1:0]      idx, idx_next;
  logic [psq_pkg::CNT_W-1:0]      count, count_next;
  logic [psq_pkg::ID_W-1:0]       head, head_next;
  psq_pkg::status_t               status_q, status_next;
  logic [psq_pkg::ID_W-1:0]       out_id_q, out_id_next;

  logic                           ram_we;
  logic [psq_pkg::IDX_W-1:0]      ram_waddr;
  logic [psq_pkg::ID_W-1:0]       ram_wdata;
  logic [psq_pkg::IDX_W-1:0]      ram_raddr;
  logic [psq_pkg::ID_W-1:0]       ram_rdata;

  logic [psq_pkg::CNT_W-1:0]      idx_plus1;
  logic [psq_pkg::CNT_W-1:0]      idx_plus2;
  logic [31:0]                    count_wide;

  // slot storage, slot 0 the oldest
  psq_ram #(
    .WIDTH (psq_pkg::ID_W),
    .DEPTH (psq_pkg::DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idx_plus1 = psq_pkg::CNT_W'(idx) + psq_pkg::CNT_W'(1);
  assign idx_plus2 = psq_pkg::CNT_W'(idx) + psq_pkg::CNT_W'(2);

  // sequencer: find and remove scan the slots, then remove and pop close the gap one slot per cycle
  always_comb begin
    state_next  = state;
    cmd_next    = cmd_q;
    id_next     = id_q;
    idx_next    = idx;
    count_next  = count;
    head_next   = head;
    status_next = status_q;
    out_id_next = out_id_q;
    ram_we      = 1'b0;
    ram_waddr   = idx;
    ram_wdata   = id_q;
    ram_raddr   = idx + psq_pkg::IDX_W'(1);

    unique case (state)
      psq_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_next    = psq_pkg::cmd_t'(command);
          id_next     = sig_id;
          idx_next    = '0;
          status_next = psq_pkg::ST_DONE;
          out_id_next = '0;
          unique case (psq_pkg::cmd_t'(command))
            psq_pkg::CMD_APPEND: begin
              state_next = psq_pkg::S_RESP;
              if (count == psq_pkg::CNT_W'(psq_pkg::DEPTH)) begin
                status_next = psq_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = count[psq_pkg::IDX_W-1:0];
                ram_wdata  = sig_id;
                count_next = count + psq_pkg::CNT_W'(1);
                if (count == '0) begin
                  head_next = sig_id;
                end
              end
            end
            psq_pkg::CMD_POP: begin
              if (count == '0) begin
                status_next = psq_pkg::ST_MISS;
                state_next  = psq_pkg::S_RESP;
              end else begin
                out_id_next = head;
                if (count == psq_pkg::CNT_W'(1)) begin
                  count_next = '0;
                  state_next = psq_pkg::S_RESP;
                end else begin
                  ram_raddr  = psq_pkg::IDX_W'(1);
                  state_next = psq_pkg::S_SHIFT;
                end
              end
            end
            psq_pkg::CMD_REMOVE, psq_pkg::CMD_FIND: begin
              if (count == '0) begin
                status_next = psq_pkg::ST_MISS;
                state_next  = psq_pkg::S_RESP;
              end else begin
                ram_raddr  = '0;
                state_next = psq_pkg::S_SCAN;
              end
            end
            default: begin
              state_next = psq_pkg::S_IDLE;
            end
          endcase
        end
      end

      // ram_rdata holds slot idx
      psq_pkg::S_SCAN: begin
        if (ram_rdata == id_q) begin
          out_id_next = ram_rdata;
          if (cmd_q == psq_pkg::CMD_FIND) begin
            state_next = psq_pkg::S_RESP;
          end else if (idx_plus1 == count) begin
            // last entry matched, nothing to move
            count_next = count - psq_pkg::CNT_W'(1);
            state_next = psq_pkg::S_RESP;
          end else begin
            state_next = psq_pkg::S_SHIFT;
          end
        end else if (idx_plus1 == count) begin
          status_next = psq_pkg::ST_MISS;
          state_next  = psq_pkg::S_RESP;
        end else begin
          idx_next = idx + psq_pkg::IDX_W'(1);
        end
      end

      // ram_rdata holds slot idx+1, moved into slot idx
      psq_pkg::S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        ram_raddr = idx + psq_pkg::IDX_W'(2);
        if (idx == '0) begin
          head_next = ram_rdata;
        end
        if (idx_plus2 == count) begin
          count_next = count - psq_pkg::CNT_W'(1);
          state_next = psq_pkg::S_RESP;
        end else begin
          idx_next = idx + psq_pkg::IDX_W'(1);
        end
      end

      psq_pkg::S_RESP: begin
        if (out_ready) begin
          state_next = psq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = psq_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_q    <= cmd_next;
    id_q     <= id_next;
    idx      <= idx_next;
    head     <= head_next;
    status_q <= status_next;
    out_id_q <= out_id_next;
  end

  // ports
  assign count_wide  = 32'(count);
  assign in_ready    = (state == psq_pkg::S_IDLE);
  assign out_valid   = (state == psq_pkg::S_RESP);
  assign status      = status_q;
  assign out_id      = out_id_q;
  assign head_valid  = (count != '0);
  assign head_id     = (count != '0) ? head : '0;
  assign entry_count = count_wide[psq_pkg::COUNT_OUT_W-1:0];

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= psq_pkg::CNT_W'(psq_pkg::DEPTH))
    else $error("entry count above depth");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while a result is pending");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count == $past(count) + psq_pkg::CNT_W'(1) ||
       count + psq_pkg::CNT_W'(1) == $past(count)))
    else $error("entry count moved by more than one");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == psq_pkg::S_IDLE || state == psq_pkg::S_SHIFT))
    else $error("slot write outside append or shift");

endmodule
